// File: rtl/skmd_pkg.sv
// ----------------------------------------------------------------------------
// skmd_pkg
// Shared types, constants and helper functions for the MD4 fold one-way
// pipeline: digest state, initial values, round constants and message
// word selection.
// ----------------------------------------------------------------------------
package skmd_pkg;

  localparam int unsigned NumRounds = 48;
  localparam int unsigned RndW      = 6;

  localparam logic [31:0] IvA = 32'h6745_2301;
  localparam logic [31:0] IvB = 32'hefcd_ab89;
  localparam logic [31:0] IvC = 32'h98ba_dcfe;
  localparam logic [31:0] IvD = 32'h1032_5476;
  localparam logic [31:0] K2  = 32'h5a82_7999;
  localparam logic [31:0] K3  = 32'h6ed9_eba1;

  // Padding word after the 8 key bytes and the bit length of the message
  localparam logic [31:0] PadWord = 32'h0000_0080;
  localparam logic [31:0] LenWord = 32'd64;

  // Round group codes
  localparam logic [1:0] GrpF = 2'd0;
  localparam logic [1:0] GrpG = 2'd1;
  localparam logic [1:0] GrpH = 2'd2;

  // Rotate amounts per group and step within a group of four
  localparam logic [4:0] RotAmt [3][4] = '{
    '{5'd3, 5'd7, 5'd11, 5'd19},
    '{5'd3, 5'd5, 5'd9,  5'd13},
    '{5'd3, 5'd9, 5'd11, 5'd15}
  };

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md_state_t;

  localparam md_state_t IvState = '{a: IvA, b: IvB, c: IvC, d: IvD};

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] w;
    w = {v, v} << s;
    return w[63:32];
  endfunction

  // Boolean function of the round group
  function automatic logic [31:0] round_fn(input logic [1:0] grp, input logic [31:0] x,
                                           input logic [31:0] y, input logic [31:0] z);
    logic [31:0] f;
    unique case (grp)
      GrpF:    f = (x & y) | (~x & z);
      GrpG:    f = (x & y) | (x & z) | (y & z);
      default: f = x ^ y ^ z;
    endcase
    return f;
  endfunction

  function automatic logic [31:0] round_const(input logic [1:0] grp);
    logic [31:0] k;
    unique case (grp)
      GrpF:    k = 32'd0;
      GrpG:    k = K2;
      default: k = K3;
    endcase
    return k;
  endfunction

  // Index of the message word used at a given step of a group
  function automatic logic [3:0] word_index(input logic [1:0] grp, input logic [3:0] step);
    logic [3:0] idx;
    unique case (grp)
      GrpF:    idx = step;
      GrpG:    idx = {step[1:0], step[3:2]};
      default: idx = {step[0], step[1], step[2], step[3]};
    endcase
    return idx;
  endfunction

  // Padded single block: key words, pad byte, zeros, length word
  function automatic logic [31:0] msg_word(input logic [63:0] key, input logic [3:0] idx);
    logic [31:0] w;
    case (idx)
      4'd0:    w = key[31:0];
      4'd1:    w = key[63:32];
      4'd2:    w = PadWord;
      4'd14:   w = LenWord;
      default: w = 32'd0;
    endcase
    return w;
  endfunction

endpackage

// File: rtl/skmd_round.sv
// ----------------------------------------------------------------------------
// skmd_round
// One MD4 step as a pipeline stage: four-input add, rotate, word shuffle.
// The key word travels along so later steps can pick their message word.
// ----------------------------------------------------------------------------
module skmd_round
  import skmd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [RndW-1:0] rnd_i,
  input  logic            valid_i,
  output logic            ready_o,
  input  md_state_t       state_i,
  input  logic [63:0]     key_i,
  output logic            valid_o,
  input  logic            ready_i,
  output md_state_t       state_o,
  output logic [63:0]     key_o
);

  logic        valid_q;
  md_state_t   state_d, state_q;
  logic [63:0] key_q;
  logic [1:0]  grp;
  logic [3:0]  step;
  logic [31:0] sum;

  assign grp  = rnd_i[5:4];
  assign step = rnd_i[3:0];

  // Accept when empty or when the word ahead moves on
  assign ready_o = !valid_q || ready_i;

  // Compute one step and rotate the registers
  always_comb begin
    sum = state_i.a + round_fn(grp, state_i.b, state_i.c, state_i.d)
        + msg_word(key_i, word_index(grp, step)) + round_const(grp);
    state_d.a = state_i.d;
    state_d.d = state_i.c;
    state_d.c = state_i.b;
    state_d.b = rotl32(sum, RotAmt[grp][step[1:0]]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Load payload only when a word enters
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      state_q <= state_d;
      key_q   <= key_i;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign key_o   = key_q;

endmodule

// File: rtl/skmd_fold.sv
// ----------------------------------------------------------------------------
// skmd_fold
// Final stage: add the initial values to the digest and fold it to 64 bits
// into the output register.
// ----------------------------------------------------------------------------
module skmd_fold
  import skmd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  md_state_t   state_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [63:0] key_o
);

  logic        valid_q;
  logic [63:0] key_d, key_q;
  logic [31:0] fa, fb, fc, fd;

  assign ready_o = !valid_q || !stall_i;

  // Finish the digest and fold A with C, B with D
  always_comb begin
    fa    = state_i.a + IvA;
    fb    = state_i.b + IvB;
    fc    = state_i.c + IvC;
    fd    = state_i.d + IvD;
    key_d = {fb ^ fd, fa ^ fc};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      key_q <= key_d;
    end
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;

endmodule

// File: rtl/skey_md4_fold_one_way.sv
// ----------------------------------------------------------------------------
// skey_md4_fold_one_way
// S/KEY one-way function: MD4 over an 8-byte key, digest folded to 64 bits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: present key_in_i with in_valid_i; a word is taken on a
//   clock edge where in_valid_i is high and in_stall_o is low.
//   Output channel: key_out_o is valid while out_valid_o is high and is
//   taken on an edge where out_stall_i is low.
//   Path: from acceptance to out_valid_o a key runs through 48 step stages,
//   one per MD4 step, then the fold/output register.
//   Throughput: one key per cycle while out_stall_i is low; the depth is
//   set by the 48 MD4 steps, each a four-input 32-bit add and a fixed rotate.
//   Stall: every stage holds when the stage ahead is full and held; empty
//   stages keep filling, so up to 49 words sit in flight. in_stall_o rises
//   only when the whole pipe is full and the output is stalled.
//   Reset: all stage valid bits clear; no words are in flight afterwards.
//   Each key yields exactly one result, in order.
// ----------------------------------------------------------------------------
module skey_md4_fold_one_way
  import skmd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] key_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] key_out_o
);

  logic        valid [NumRounds+1];
  logic        ready [NumRounds+1];
  md_state_t   state [NumRounds+1];
  logic [63:0] key   [NumRounds+1];

  // Feed the first stage with the initial digest state
  assign valid[0]   = in_valid_i;
  assign state[0]   = IvState;
  assign key[0]     = key_in_i;
  assign in_stall_o = !ready[0];

  // One stage per MD4 step
  for (genvar g = 0; g < NumRounds; g++) begin : g_step
    skmd_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .rnd_i   (RndW'(g)),
      .valid_i (valid[g]),
      .ready_o (ready[g]),
      .state_i (state[g]),
      .key_i   (key[g]),
      .valid_o (valid[g+1]),
      .ready_i (ready[g+1]),
      .state_o (state[g+1]),
      .key_o   (key[g+1])
    );
  end

  // Finish, fold and hold the result
  skmd_fold u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid[NumRounds]),
    .ready_o (ready[NumRounds]),
    .state_i (state[NumRounds]),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .key_o   (key_out_o)
  );

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks skey_md4_fold_one_way. Each key taken by the block is run through
// a local MD4 fold (single padded block, A^C and B^D) to predict its result.
// Each word taken from the output is compared in order with that prediction.
// Both channels see random gaps and stalls: most are short, a few are long.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // MD4 initial chaining words, round constants and padding of an 8-byte key
  localparam logic [31:0] InitA     = 32'h6745_2301;
  localparam logic [31:0] InitB     = 32'hefcd_ab89;
  localparam logic [31:0] InitC     = 32'h98ba_dcfe;
  localparam logic [31:0] InitD     = 32'h1032_5476;
  localparam logic [31:0] RootTwo   = 32'h5a82_7999;
  localparam logic [31:0] RootThree = 32'h6ed9_eba1;
  localparam logic [31:0] PadByte   = 32'h0000_0080;
  localparam logic [31:0] BitLen    = 32'd64;

  // Rotate amounts of the four steps in a group, 5 bits each, step 0 lowest
  localparam logic [19:0] ShiftF = {5'd19, 5'd11, 5'd7, 5'd3};
  localparam logic [19:0] ShiftG = {5'd13, 5'd9, 5'd5, 5'd3};
  localparam logic [19:0] ShiftH = {5'd15, 5'd11, 5'd9, 5'd3};

  // Pipeline depth plus margin, waited out after the last result
  localparam int unsigned SettleCycles = 60;

  typedef enum logic [1:0] {MixF, MixG, MixH} mix_grp_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] key_in_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] key_out_o;

  // Folded digests of accepted keys, oldest first
  logic [63:0] fold_q [$];
  int unsigned mismatch_cnt = 0;

  skey_md4_fold_one_way dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .key_in_i    (key_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .key_out_o   (key_out_o)
  );

  always #5ns clk_i = ~clk_i;

  // MD4 over the key as one padded block, digest folded to 64 bits
  function automatic logic [63:0] md4_fold(input logic [63:0] key);
    logic [31:0] blk [16];
    logic [31:0] a, b, c, d, f, k, t;
    logic [3:0]  s, idx;
    int unsigned sh;
    mix_grp_e    grp;
    foreach (blk[i]) blk[i] = 32'd0;
    blk[0]  = key[31:0];
    blk[1]  = key[63:32];
    blk[2]  = PadByte;
    blk[14] = BitLen;
    a = InitA;
    b = InitB;
    c = InitC;
    d = InitD;
    for (int g = 0; g < 3; g++) begin
      grp = mix_grp_e'(g);
      for (int n = 0; n < 16; n++) begin
        s = 4'(n);
        case (grp)
          MixF: begin
            f   = (b & c) | (~b & d);
            k   = 32'd0;
            idx = s;
            sh  = ShiftF[5*s[1:0] +: 5];
          end
          MixG: begin
            f   = (b & c) | (b & d) | (c & d);
            k   = RootTwo;
            idx = {s[1:0], s[3:2]};
            sh  = ShiftG[5*s[1:0] +: 5];
          end
          default: begin
            f   = b ^ c ^ d;
            k   = RootThree;
            idx = {s[0], s[1], s[2], s[3]};
            sh  = ShiftH[5*s[1:0] +: 5];
          end
        endcase
        t = a + f + blk[idx] + k;
        t = (t << sh) | (t >> (32 - sh));
        a = d;
        d = c;
        c = b;
        b = t;
      end
    end
    a = a + InitA;
    b = b + InitB;
    c = c + InitC;
    d = d + InitD;
    return {b ^ d, a ^ c};
  endfunction

  // Idle cycles after a word: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    if (roll < 98) return $urandom_range(10, 4);
    return $urandom_range(80, 20);
  endfunction

  // Offer one key, hold it until taken, then idle for gap cycles
  task automatic send_key(input logic [63:0] key, input int unsigned gap);
    key_in_i   <= key;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      key_in_i   <= {$urandom, $urandom};
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Predict each accepted key, then check each word taken from the output
  always @(posedge clk_i) begin : fold_check
    logic [63:0] want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) fold_q.push_back(md4_fold(key_in_i));
      if (out_valid_o && !out_stall_i) begin
        if (fold_q.size() == 0) begin
          $display("%0t tb: key_out unexpected: expected none, got %h", $time, key_out_o);
          mismatch_cnt++;
        end else begin
          want = fold_q.pop_front();
          if (key_out_o !== want) begin
            $display("%0t tb: key_out mismatch: expected %h, got %h", $time, want,
                     key_out_o);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // Stall the output in bursts; long ones back the pipe up to the input
  initial begin : out_stall_gen
    int unsigned span;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(99) < 3) span = $urandom_range(150, 60);
      else span = $urandom_range(3, 1);
      out_stall_i <= 1'b1;
      repeat (span) @(posedge clk_i);
      if ($urandom_range(99) < 10) span = $urandom_range(200, 30);
      else span = $urandom_range(8, 1);
      out_stall_i <= 1'b0;
      repeat (span) @(posedge clk_i);
    end
  end

  // Extremes, bit patterns, seven-bit boundaries and a repeated key
  task automatic test_corner_keys();
    logic [63:0] keys [$];
    keys = {64'h0, 64'hffff_ffff_ffff_ffff, 64'h0123_4567_89ab_cdef,
            64'hfedc_ba98_7654_3210, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
            64'h1, 64'h8000_0000_0000_0000, 64'h80, 64'h8080_8080_8080_8080,
            64'h7f7f_7f7f_7f7f_7f7f, 64'h0000_0000_ffff_ffff, 64'hffff_ffff_0000_0000,
            64'h0000_0000_8000_0000, 64'h0000_0001_0000_0000, 64'h6867_6665_6463_6261,
            64'h6867_6665_6463_6261};
    foreach (keys[i]) send_key(keys[i], pick_gap());
  endtask

  // Walking ones and zeros, then keys a few bits away from all-zero or all-one
  task automatic test_sparse_keys();
    logic [63:0] key;
    for (int i = 0; i < 64; i++) send_key(64'h1 << i, pick_gap());
    for (int i = 0; i < 64; i++) send_key(~(64'h1 << i), pick_gap());
    for (int i = 0; i < 200; i++) begin
      key = ($urandom_range(1) != 0) ? '1 : '0;
      repeat ($urandom_range(3, 1)) key[$urandom_range(63)] ^= 1'b1;
      send_key(key, pick_gap());
    end
  endtask

  // Back-to-back keys so that output stalls fill the pipe
  task automatic test_full_pipe(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_key({$urandom, $urandom}, 0);
  endtask

  // Random keys in stretches, some with no gaps, some bytes forced to edges
  task automatic test_random_keys(input int unsigned count);
    logic [63:0] key;
    bit          burst;
    burst = 1'b0;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) burst = ($urandom_range(3) == 0);
      key = {$urandom, $urandom};
      if ($urandom_range(3) == 0) begin
        for (int j = 0; j < 8; j++) begin
          case ($urandom_range(7))
            0: key[8*j +: 8] = 8'h00;
            1: key[8*j +: 8] = 8'hff;
            2: key[8*j +: 8] = 8'h80;
            3: key[8*j +: 8] = 8'h7f;
            default: ;
          endcase
        end
      end
      send_key(key, burst ? 0 : pick_gap());
    end
  endtask

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    key_in_i   <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_corner_keys();
    test_sparse_keys();
    test_full_pipe(200);
    test_random_keys(1200);

    // Drain, then give a stray late word time to show up
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (fold_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #15ms;
    $display("tb: errors");
    $finish;
  end

endmodule
